>>> rtl/ocao_pkg.sv
// ocao_pkg: shared types, widths, constants and helper functions
// for the orbit camera angle and offset step block
// no dependencies
package ocao_pkg;

   localparam int DT_W       = 16;
   localparam int STICK_W    = 16;
   localparam int RATE_W     = 15;
   localparam int RADIUS_W   = 16;
   localparam int PITCH_W    = 14;
   localparam int ANG_W      = 15;
   localparam int VEC_W      = 16;
   localparam int OFF_W      = 17;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MUL_A_W    = 34;
   localparam int MUL_B_W    = 17;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int RATE_P_W   = STICK_W + RATE_W;
   localparam int MOVE_P_W   = RATE_P_W + DT_W;
   localparam int MOVE_SHIFT = 30;
   localparam int DELTA_W    = MOVE_P_W + 1 - MOVE_SHIFT;
   localparam int WRAP_W     = DELTA_W + 1;

   localparam int CORDIC_W   = 34;
   localparam int CZ_W       = 20;

   localparam int YAW_LIMIT  = 12868;
   localparam int YAW_PERIOD = 25736;
   localparam int UNIT_Q14   = 16384;
   localparam int OFFSET_MAX = 65535;

   localparam logic signed [CZ_W-1:0]     QUARTER_TURN = 20'sd102944;
   localparam logic signed [CZ_W-1:0]     HALF_TURN    = 20'sd205888;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

   localparam logic [CSR_IDX_W-1:0] CSR_YAW_RATE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_FLOOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_CEILING = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORBIT_RADIUS  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_YR,
      ST_MUL_YT,
      ST_MUL_PR,
      ST_MUL_PT,
      ST_PITCH,
      ST_WRAP,
      ST_TRIG_YAW,
      ST_TRIG_PITCH,
      ST_MUL_RC,
      ST_MUL_RS,
      ST_MUL_XS,
      ST_MUL_ZC,
      ST_OFF_Z,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } cordic_ctl_type;

   function automatic logic signed [CZ_W-1:0] atan_lookup(input logic [3:0] idx);
      logic signed [CZ_W-1:0] v;
      unique case (idx)
         4'd0:  v = 20'sd51472;
         4'd1:  v = 20'sd30386;
         4'd2:  v = 20'sd16055;
         4'd3:  v = 20'sd8150;
         4'd4:  v = 20'sd4091;
         4'd5:  v = 20'sd2047;
         4'd6:  v = 20'sd1024;
         4'd7:  v = 20'sd512;
         4'd8:  v = 20'sd256;
         4'd9:  v = 20'sd128;
         4'd10: v = 20'sd64;
         4'd11: v = 20'sd32;
         4'd12: v = 20'sd16;
         4'd13: v = 20'sd8;
         4'd14: v = 20'sd4;
         4'd15: v = 20'sd2;
      endcase
      return v;
   endfunction

   // round at bit 16 and clamp to the unit range
   function automatic logic signed [VEC_W-1:0] trig_round(
      input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] t;
      t = (v + $signed(CORDIC_W'(32768))) >>> 16;
      if (t > UNIT_Q14) begin
         return VEC_W'(UNIT_Q14);
      end else if (t < -UNIT_Q14) begin
         return VEC_W'(-UNIT_Q14);
      end
      return VEC_W'(t);
   endfunction

   function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [MUL_P_W-1:0] v);
      if (v > OFFSET_MAX) begin
         return OFF_W'(OFFSET_MAX);
      end else if (v < -OFFSET_MAX) begin
         return OFF_W'(-OFFSET_MAX);
      end
      return OFF_W'(v);
   endfunction

endpackage

>>> rtl/ocao_mul.sv
// ocao_mul: shared signed multiplier with registered product
// depends on ocao_pkg
module ocao_mul (
   input  logic                                clock,
   input  logic signed [ocao_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [ocao_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [ocao_pkg::MUL_P_W-1:0] prod_ff
);
   import ocao_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/ocao_cordic.sv
// ocao_cordic: iterative sine and cosine unit, one rotation step per cycle while step is asserted
// depends on ocao_pkg
module ocao_cordic #(
   parameter int TRIG_ITERATIONS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ocao_pkg::cordic_ctl_type          ctl,
   input  logic signed [ocao_pkg::ANG_W-1:0] angle,
   output logic                              done,
   output logic signed [ocao_pkg::VEC_W-1:0] sin_q,
   output logic signed [ocao_pkg::VEC_W-1:0] cos_q
);
   import ocao_pkg::*;

   localparam int ITERS = (TRIG_ITERATIONS > 16) ? 16 : TRIG_ITERATIONS;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic signed [CORDIC_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [CZ_W-1:0]     z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [CZ_W-1:0]     z_scaled;
   logic signed [CORDIC_W-1:0] x_sh, y_sh, x_out, y_out;
   logic signed [CZ_W-1:0]     atan_val;

   assign done     = (cnt_ff == CNT_W'(ITERS));
   assign z_scaled = CZ_W'(angle) <<< 4;
   assign x_sh     = x_ff >>> cnt_ff[3:0];
   assign y_sh     = y_ff >>> cnt_ff[3:0];
   assign atan_val = atan_lookup(cnt_ff[3:0]);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         x_in    = CORDIC_START;
         y_in    = '0;
         cnt_in  = '0;
         // fold into the right half plane
         if (z_scaled > QUARTER_TURN) begin
            z_in    = z_scaled - HALF_TURN;
            flip_in = 1'b1;
         end else if (z_scaled < -QUARTER_TURN) begin
            z_in    = z_scaled + HALF_TURN;
            flip_in = 1'b1;
         end else begin
            z_in    = z_scaled;
            flip_in = 1'b0;
         end
      end else if (ctl.step && !done) begin
         if (z_ff[CZ_W-1]) begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(ITERS);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign x_out = flip_ff ? -x_ff : x_ff;
   assign y_out = flip_ff ? -y_ff : y_ff;
   assign sin_q = trig_round(y_out);
   assign cos_q = trig_round(x_out);

endmodule

>>> rtl/orbit_camera_angle_offset_step.sv
// orbit_camera_angle_offset_step: top level, sequencer and angle/offset datapath
// depends on ocao_pkg, ocao_mul, ocao_cordic
// a new request is taken only in the idle state, once the previous result has gone to the
//   result register; the yaw wrap adds or subtracts a period until the yaw is in range;
//   the shared cordic unit runs yaw then pitch and the single shared multiplier is used
//   for every product
// reset: synchronous, registers to reset values, angles to zero, no result held
module orbit_camera_angle_offset_step #(
   parameter int TRIG_ITERATIONS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic        [ocao_pkg::DT_W-1:0]       req_time_step,
   input  logic signed [ocao_pkg::STICK_W-1:0]    req_stick_x,
   input  logic signed [ocao_pkg::STICK_W-1:0]    req_stick_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ocao_pkg::OFF_W-1:0]      rsp_offset_x,
   output logic signed [ocao_pkg::OFF_W-1:0]      rsp_offset_y,
   output logic signed [ocao_pkg::OFF_W-1:0]      rsp_offset_z,
   output logic signed [ocao_pkg::VEC_W-1:0]      rsp_forward_x,
   output logic signed [ocao_pkg::VEC_W-1:0]      rsp_forward_z,
   output logic signed [ocao_pkg::VEC_W-1:0]      rsp_right_x,
   output logic signed [ocao_pkg::VEC_W-1:0]      rsp_right_z,
   output logic signed [ocao_pkg::ANG_W-1:0]      rsp_yaw_now,
   output logic signed [ocao_pkg::PITCH_W-1:0]    rsp_pitch_now,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [ocao_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [ocao_pkg::CSR_DATA_W-1:0] csr_data
);
   import ocao_pkg::*;

   state_type state_ff, state_in;

   logic        [RATE_W-1:0]   yaw_rate_ff, pitch_rate_ff;
   logic signed [PITCH_W-1:0]  pitch_floor_ff, pitch_ceiling_ff;
   logic        [RADIUS_W-1:0] orbit_radius_ff;

   logic signed [ANG_W-1:0]    yaw_ff;
   logic signed [PITCH_W-1:0]  pitch_ff, pitch_in;

   logic        [DT_W-1:0]     dt_ff;
   logic        [STICK_W-1:0]  mag_x_ff, mag_y_ff;
   logic                       neg_x_ff, neg_y_ff;
   logic signed [WRAP_W-1:0]   wrap_ff;

   logic signed [VEC_W-1:0]    syaw_ff, cyaw_ff, sp_ff, cp_ff;
   logic signed [MUL_A_W-1:0]  rcp_ff;
   logic signed [OFF_W-1:0]    off_x_ff, off_y_ff, off_z_ff;

   logic                       rsp_valid_ff;
   logic signed [OFF_W-1:0]    rsp_offset_x_ff, rsp_offset_y_ff, rsp_offset_z_ff;
   logic signed [VEC_W-1:0]    rsp_forward_x_ff, rsp_forward_z_ff;
   logic signed [VEC_W-1:0]    rsp_right_x_ff, rsp_right_z_ff;
   logic signed [ANG_W-1:0]    rsp_yaw_now_ff;
   logic signed [PITCH_W-1:0]  rsp_pitch_now_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_ff;

   cordic_ctl_type             cordic_ctl;
   logic signed [ANG_W-1:0]    cordic_angle;
   logic                       cordic_done;
   logic signed [VEC_W-1:0]    cordic_sin, cordic_cos;

   logic                       req_xfer, rsp_free, wrap_ok, delta_neg;
   logic        [MOVE_P_W:0]   move_sum;
   logic        [DELTA_W-1:0]  delta_mag;
   logic signed [WRAP_W-1:0]   delta_val, pitch_diff, ceil_ext, floor_ext;
   logic signed [ANG_W-1:0]    yaw_wrapped;
   logic signed [MUL_P_W-1:0]  rnd14, rnd28;

   ocao_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_ff)
   );

   ocao_cordic #(
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl   (cordic_ctl),
      .angle (cordic_angle),
      .done  (cordic_done),
      .sin_q (cordic_sin),
      .cos_q (cordic_cos)
   );

   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // angle change, rounded half away from zero
   assign move_sum  = {1'b0, mul_ff[MOVE_P_W-1:0]} + ((MOVE_P_W+1)'(1) << (MOVE_SHIFT - 1));
   assign delta_mag = move_sum[MOVE_P_W:MOVE_SHIFT];
   assign delta_neg = (state_ff == ST_MUL_PR) ? neg_x_ff : neg_y_ff;
   assign delta_val = delta_neg ? -$signed({1'b0, delta_mag}) : $signed({1'b0, delta_mag});

   assign wrap_ok     = !wrap_ff[WRAP_W-1] && (wrap_ff < YAW_PERIOD);
   assign yaw_wrapped = ANG_W'(wrap_ff - WRAP_W'(YAW_LIMIT));

   assign pitch_diff = WRAP_W'(pitch_ff) - delta_val;
   assign ceil_ext   = WRAP_W'(pitch_ceiling_ff);
   assign floor_ext  = WRAP_W'(pitch_floor_ff);

   // ceiling first, floor wins when the limits cross
   always_comb begin
      pitch_in = PITCH_W'(pitch_diff);
      if (pitch_diff > ceil_ext) begin
         pitch_in = pitch_ceiling_ff;
      end
      if (pitch_diff < floor_ext || (pitch_diff > ceil_ext && ceil_ext < floor_ext)) begin
         pitch_in = pitch_floor_ff;
      end
   end

   assign rnd14 = (mul_ff + $signed(MUL_P_W'(1) << 13)) >>> 14;
   assign rnd28 = (mul_ff + $signed(MUL_P_W'(1) << 27)) >>> 28;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_xfer) state_in = ST_MUL_YR;
         ST_MUL_YR:     state_in = ST_MUL_YT;
         ST_MUL_YT:     state_in = ST_MUL_PR;
         ST_MUL_PR:     state_in = ST_MUL_PT;
         ST_MUL_PT:     state_in = ST_PITCH;
         ST_PITCH:      state_in = ST_WRAP;
         ST_WRAP:       if (wrap_ok) state_in = ST_TRIG_YAW;
         ST_TRIG_YAW:   if (cordic_done) state_in = ST_TRIG_PITCH;
         ST_TRIG_PITCH: if (cordic_done) state_in = ST_MUL_RC;
         ST_MUL_RC:     state_in = ST_MUL_RS;
         ST_MUL_RS:     state_in = ST_MUL_XS;
         ST_MUL_XS:     state_in = ST_MUL_ZC;
         ST_MUL_ZC:     state_in = ST_OFF_Z;
         ST_OFF_Z:      state_in = ST_DONE;
         ST_DONE:       if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      cordic_ctl.start = 1'b0;
      cordic_ctl.step  = 1'b0;
      cordic_angle     = ANG_W'(pitch_ff);
      mul_a            = '0;
      mul_b            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MUL_YR: begin
            mul_a = $signed(MUL_A_W'(mag_x_ff));
            mul_b = $signed(MUL_B_W'(yaw_rate_ff));
         end
         ST_MUL_YT, ST_MUL_PT: begin
            mul_a = $signed(MUL_A_W'(mul_ff[RATE_P_W-1:0]));
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         ST_MUL_PR: begin
            mul_a = $signed(MUL_A_W'(mag_y_ff));
            mul_b = $signed(MUL_B_W'(pitch_rate_ff));
         end
         ST_WRAP: begin
            cordic_angle     = yaw_wrapped;
            cordic_ctl.start = wrap_ok;
         end
         ST_TRIG_YAW: begin
            cordic_ctl.step  = !cordic_done;
            cordic_ctl.start = cordic_done;
         end
         ST_TRIG_PITCH: begin
            cordic_ctl.step = !cordic_done;
         end
         ST_MUL_RC: begin
            mul_a = $signed(MUL_A_W'(orbit_radius_ff));
            mul_b = MUL_B_W'(cp_ff);
         end
         ST_MUL_RS: begin
            mul_a = $signed(MUL_A_W'(orbit_radius_ff));
            mul_b = MUL_B_W'(sp_ff);
         end
         ST_MUL_XS: begin
            mul_a = rcp_ff;
            mul_b = MUL_B_W'(syaw_ff);
         end
         ST_MUL_ZC: begin
            mul_a = rcp_ff;
            mul_b = MUL_B_W'(cyaw_ff);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_rate_ff      <= RATE_W'(4096);
         pitch_rate_ff    <= RATE_W'(4096);
         pitch_floor_ff   <= PITCH_W'(-5792);
         pitch_ceiling_ff <= PITCH_W'(5792);
         orbit_radius_ff  <= RADIUS_W'(2560);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_YAW_RATE:      yaw_rate_ff      <= csr_data[RATE_W-1:0];
            CSR_PITCH_RATE:    pitch_rate_ff    <= csr_data[RATE_W-1:0];
            CSR_PITCH_FLOOR:   pitch_floor_ff   <= $signed(csr_data[PITCH_W-1:0]);
            CSR_PITCH_CEILING: pitch_ceiling_ff <= $signed(csr_data[PITCH_W-1:0]);
            CSR_ORBIT_RADIUS:  orbit_radius_ff  <= csr_data[RADIUS_W-1:0];
            default:           yaw_rate_ff      <= yaw_rate_ff;
         endcase
      end
   end

   // angle state
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= '0;
         pitch_ff <= '0;
      end else begin
         if (state_ff == ST_PITCH) begin
            pitch_ff <= pitch_in;
         end
         if (state_ff == ST_WRAP && wrap_ok) begin
            yaw_ff <= yaw_wrapped;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dt_ff    <= req_time_step;
         neg_x_ff <= req_stick_x[STICK_W-1];
         neg_y_ff <= req_stick_y[STICK_W-1];
         mag_x_ff <= req_stick_x[STICK_W-1] ? STICK_W'(-req_stick_x) : STICK_W'(req_stick_x);
         mag_y_ff <= req_stick_y[STICK_W-1] ? STICK_W'(-req_stick_y) : STICK_W'(req_stick_y);
      end
      if (state_ff == ST_MUL_PR) begin
         wrap_ff <= WRAP_W'(yaw_ff) - delta_val + WRAP_W'(YAW_LIMIT);
      end else if (state_ff == ST_WRAP && !wrap_ok) begin
         if (wrap_ff[WRAP_W-1]) begin
            wrap_ff <= wrap_ff + WRAP_W'(YAW_PERIOD);
         end else begin
            wrap_ff <= wrap_ff - WRAP_W'(YAW_PERIOD);
         end
      end
      if (state_ff == ST_TRIG_YAW && cordic_done) begin
         syaw_ff <= cordic_sin;
         cyaw_ff <= cordic_cos;
      end
      if (state_ff == ST_TRIG_PITCH && cordic_done) begin
         sp_ff <= cordic_sin;
         cp_ff <= cordic_cos;
      end
      if (state_ff == ST_MUL_RS) begin
         rcp_ff <= mul_ff[MUL_A_W-1:0];
      end
      if (state_ff == ST_MUL_XS) begin
         off_y_ff <= sat_off(rnd14);
      end
      if (state_ff == ST_MUL_ZC) begin
         off_x_ff <= sat_off(rnd28);
      end
      if (state_ff == ST_OFF_Z) begin
         off_z_ff <= sat_off(-rnd28);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_offset_x_ff  <= off_x_ff;
         rsp_offset_y_ff  <= off_y_ff;
         rsp_offset_z_ff  <= off_z_ff;
         rsp_forward_x_ff <= -syaw_ff;
         rsp_forward_z_ff <= cyaw_ff;
         rsp_right_x_ff   <= cyaw_ff;
         rsp_right_z_ff   <= syaw_ff;
         rsp_yaw_now_ff   <= yaw_ff;
         rsp_pitch_now_ff <= pitch_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_offset_x  = rsp_offset_x_ff;
   assign rsp_offset_y  = rsp_offset_y_ff;
   assign rsp_offset_z  = rsp_offset_z_ff;
   assign rsp_forward_x = rsp_forward_x_ff;
   assign rsp_forward_z = rsp_forward_z_ff;
   assign rsp_right_x   = rsp_right_x_ff;
   assign rsp_right_z   = rsp_right_z_ff;
   assign rsp_yaw_now   = rsp_yaw_now_ff;
   assign rsp_pitch_now = rsp_pitch_now_ff;

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (yaw_ff >= -YAW_LIMIT) && (yaw_ff < YAW_LIMIT))
      else $error("yaw outside wrap range");

   a_pitch_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PITCH) |=> (pitch_ff <= pitch_ceiling_ff || pitch_ff == pitch_floor_ff))
      else $error("pitch not clamped");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   a_unit_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_right_x_ff <= UNIT_Q14 && rsp_right_x_ff >= -UNIT_Q14
                        && rsp_right_z_ff <= UNIT_Q14 && rsp_right_z_ff >= -UNIT_Q14))
      else $error("direction vector out of unit range");

endmodule

>>> bench/tb_orbit_camera_angle_offset_step.sv
// self-checking bench for orbit_camera_angle_offset_step: directed and random stick moves
// are checked field by field against an in-bench model of the angle, trig and offset math
// depends on ocao_pkg and the rtl top level
module tb_orbit_camera_angle_offset_step;
   import ocao_pkg::*;

   localparam int TRIG_STEPS      = 14;
   localparam int RANDOM_PHASES   = 12;
   localparam int MOVES_PER_PHASE = 104;
   localparam int STEADY_PHASE    = 6;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int SHOW_LIMIT      = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic        [DT_W-1:0]    dt;
      logic signed [STICK_W-1:0] sx;
      logic signed [STICK_W-1:0] sy;
   } stick_move_t;

   typedef struct packed {
      logic signed [OFF_W-1:0]   off_x;
      logic signed [OFF_W-1:0]   off_y;
      logic signed [OFF_W-1:0]   off_z;
      logic signed [VEC_W-1:0]   fwd_x;
      logic signed [VEC_W-1:0]   fwd_z;
      logic signed [VEC_W-1:0]   rgt_x;
      logic signed [VEC_W-1:0]   rgt_z;
      logic signed [ANG_W-1:0]   yaw;
      logic signed [PITCH_W-1:0] pitch;
   } camera_view_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DT_W-1:0] req_time_step = '0;
   logic signed [STICK_W-1:0] req_stick_x = '0;
   logic signed [STICK_W-1:0] req_stick_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OFF_W-1:0] rsp_offset_x, rsp_offset_y, rsp_offset_z;
   logic signed [VEC_W-1:0] rsp_forward_x, rsp_forward_z, rsp_right_x, rsp_right_z;
   logic signed [ANG_W-1:0] rsp_yaw_now;
   logic signed [PITCH_W-1:0] rsp_pitch_now;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   stick_move_t  pending_moves[$];
   camera_view_t views_due[$];
   bit  req_fire = 1'b0;
   bit  steady = 1'b0;
   int  queued = 0;
   int  req_accepted = 0;
   int  results_seen = 0;
   int  settings_used = 1;
   int  errors = 0;
   int  quiet_cycles = 0;

   // shadow registers and angle state
   logic [RATE_W-1:0]   yaw_rate_q;
   logic [RATE_W-1:0]   pitch_rate_q;
   int                  floor_q;
   int                  ceil_q;
   logic [RADIUS_W-1:0] radius_q;
   int                  yaw_q;
   int                  pitch_q;

   longint arc_q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};

   orbit_camera_angle_offset_step #(
      .TRIG_ITERATIONS(TRIG_STEPS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_time_step(req_time_step),
      .req_stick_x(req_stick_x),
      .req_stick_y(req_stick_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_offset_x(rsp_offset_x),
      .rsp_offset_y(rsp_offset_y),
      .rsp_offset_z(rsp_offset_z),
      .rsp_forward_x(rsp_forward_x),
      .rsp_forward_z(rsp_forward_z),
      .rsp_right_x(rsp_right_x),
      .rsp_right_z(rsp_right_z),
      .rsp_yaw_now(rsp_yaw_now),
      .rsp_pitch_now(rsp_pitch_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint angle_delta(input longint stick, input longint rate,
                                          input longint dt);
      longint mag;
      longint d;
      mag = (stick < 0) ? -stick : stick;
      d = (mag * rate * dt + 64'sd536870912) >>> 30;
      return (stick < 0) ? -d : d;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic int unit_clamp(input longint v);
      if (v > UNIT_Q14) begin
         return UNIT_Q14;
      end else if (v < -UNIT_Q14) begin
         return -UNIT_Q14;
      end
      return int'(v);
   endfunction

   function automatic longint offset_clamp(input longint v);
      if (v > OFFSET_MAX) begin
         return OFFSET_MAX;
      end else if (v < -OFFSET_MAX) begin
         return -OFFSET_MAX;
      end
      return v;
   endfunction

   function automatic void sin_cos(input int ang, output int s, output int c);
      longint z;
      longint x;
      longint y;
      longint t;
      bit     flip;
      int     i;
      z = longint'(ang) * 16;
      x = CORDIC_START;
      y = 0;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
         z = z - HALF_TURN;
         flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z = z + HALF_TURN;
         flip = 1'b1;
      end
      for (i = 0; i < TRIG_STEPS && i < 16; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arc_q16[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arc_q16[i];
         end
         x = t;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = unit_clamp(round_shift(y, 16));
      c = unit_clamp(round_shift(x, 16));
   endfunction

   // advances the shadow angles and returns the expected view
   function automatic camera_view_t step_camera(input stick_move_t mv);
      int           y;
      int           p;
      int           m;
      int           syaw;
      int           cyaw;
      int           sp;
      int           cp;
      longint       r;
      camera_view_t v;
      r = longint'(radius_q);
      y = yaw_q - int'(angle_delta(mv.sx, yaw_rate_q, mv.dt));
      m = (y + YAW_LIMIT) % YAW_PERIOD;
      if (m < 0) begin
         m = m + YAW_PERIOD;
      end
      y = m - YAW_LIMIT;
      p = pitch_q - int'(angle_delta(mv.sy, pitch_rate_q, mv.dt));
      if (p > ceil_q) begin
         p = ceil_q;
      end
      if (p < floor_q) begin
         p = floor_q;
      end
      yaw_q = y;
      pitch_q = p;
      sin_cos(y, syaw, cyaw);
      sin_cos(p, sp, cp);
      v.off_x = OFF_W'(offset_clamp(round_shift(r * cp * syaw, 28)));
      v.off_y = OFF_W'(offset_clamp(round_shift(r * sp, 14)));
      v.off_z = OFF_W'(offset_clamp(-round_shift(r * cp * cyaw, 28)));
      v.fwd_x = VEC_W'(-syaw);
      v.fwd_z = VEC_W'(cyaw);
      v.rgt_x = VEC_W'(cyaw);
      v.rgt_z = VEC_W'(syaw);
      v.yaw   = ANG_W'(y);
      v.pitch = PITCH_W'(p);
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= SHOW_LIMIT) begin
         $display("mismatch: %s", msg);
      end
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                   results_seen, name, got, want));
      end
   endtask

   always @(posedge clock) begin : monitor
      camera_view_t due;
      if (reset) begin
         req_fire <= 1'b0;
         yaw_rate_q = 15'd4096;
         pitch_rate_q = 15'd4096;
         floor_q = -5792;
         ceil_q = 5792;
         radius_q = 16'd2560;
         yaw_q = 0;
         pitch_q = 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_YAW_RATE:      yaw_rate_q = csr_data[RATE_W-1:0];
               CSR_PITCH_RATE:    pitch_rate_q = csr_data[RATE_W-1:0];
               CSR_PITCH_FLOOR:   floor_q = int'($signed(csr_data[PITCH_W-1:0]));
               CSR_PITCH_CEILING: ceil_q = int'($signed(csr_data[PITCH_W-1:0]));
               CSR_ORBIT_RADIUS:  radius_q = csr_data[RADIUS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            views_due.push_back(step_camera('{dt: req_time_step, sx: req_stick_x,
                                               sy: req_stick_y}));
            req_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (views_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing due",
                                         results_seen));
            end else begin
               due = views_due.pop_front();
               check_field("offset_x", rsp_offset_x, due.off_x);
               check_field("offset_y", rsp_offset_y, due.off_y);
               check_field("offset_z", rsp_offset_z, due.off_z);
               check_field("forward_x", rsp_forward_x, due.fwd_x);
               check_field("forward_z", rsp_forward_z, due.fwd_z);
               check_field("right_x", rsp_right_x, due.rgt_x);
               check_field("right_z", rsp_right_z, due.rgt_z);
               check_field("yaw_now", rsp_yaw_now, due.yaw);
               check_field("pitch_now", rsp_pitch_now, due.pitch);
            end
         end
      end
   end

   always @(negedge clock) begin : driver
      stick_move_t cur;
      bit          pause;
      pause = !steady && ($urandom_range(0, 99) < 32);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_moves.size() != 0 && !pause) begin
            cur = pending_moves.pop_front();
            req_valid <= 1'b1;
            req_time_step <= cur.dt;
            req_stick_x <= cur.sx;
            req_stick_y <= cur.sy;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_move(input logic [DT_W-1:0] dt, input int sx, input int sy);
      pending_moves.push_back('{dt: dt, sx: STICK_W'(sx), sy: STICK_W'(sy)});
      queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_accepted != queued || views_due.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] random_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return RATE_W'($urandom_range(1, 8192));
         default: return RATE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [STICK_W-1:0] random_axis();
      case ($urandom_range(0, 9))
         0, 1: return STICK_W'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: return -16'sd32768;
               1: return -16'sd16384;
               2: return 16'sd16384;
               default: return 16'sd32767;
            endcase
         end
         3: return '0;
         default: return STICK_W'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic pick_settings();
      int lo;
      int hi;
      logic [RADIUS_W-1:0] rad;
      write_reg(CSR_YAW_RATE, {1'($urandom), random_rate()});
      write_reg(CSR_PITCH_RATE, {1'($urandom), random_rate()});
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom_range(0, 6434);
            hi = -int'($urandom_range(0, 6434));
         end
         1: begin
            lo = int'($signed(14'($urandom)));
            hi = int'($signed(14'($urandom)));
         end
         2: begin
            lo = -6434;
            hi = 6434;
         end
         3: begin
            lo = -8192;
            hi = 8191;
         end
         default: begin
            lo = -int'($urandom_range(0, 6434));
            hi = $urandom_range(0, 6434);
         end
      endcase
      write_reg(CSR_PITCH_FLOOR, {2'($urandom), 14'(lo)});
      write_reg(CSR_PITCH_CEILING, {2'($urandom), 14'(hi)});
      case ($urandom_range(0, 5))
         0: rad = '0;
         1: rad = '1;
         2: rad = RADIUS_W'($urandom_range(1, 4096));
         default: rad = RADIUS_W'($urandom);
      endcase
      write_reg(CSR_ORBIT_RADIUS, rad);
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_LOW, CSR_SPARE_HIGH)),
                   CSR_DATA_W'($urandom));
      end
      settings_used++;
   endtask

   initial begin : stimulus
      int phase;
      int k;
      logic [DT_W-1:0] dt;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: recompute, full swings, half rounding, yaw wrap, both limits
      queue_move(0, 0, 0);
      queue_move(65535, 16384, 16384);
      queue_move(65535, -16384, -16384);
      queue_move(16, 8192, -8192);
      queue_move(65535, -32768, -32768);
      queue_move(65535, -32768, 0);
      queue_move(65535, -32768, 0);
      queue_move(0, -32768, 32767);
      queue_move(65535, 32767, 32767);
      queue_move(65535, 32767, 32767);
      queue_move(65535, 32767, 32767);
      queue_move(1, 1, -1);
      queue_move(32768, 16384, 0);
      wait_idle();

      // crossed limits, dropped upper bits, spare indexes
      write_reg(CSR_PITCH_FLOOR, 16'hC7D0);
      write_reg(CSR_PITCH_CEILING, 16'h7830);
      write_reg(CSR_YAW_RATE, 16'hFFFF);
      write_reg(CSR_PITCH_RATE, 16'h8000);
      write_reg(CSR_ORBIT_RADIUS, 16'hFFFF);
      write_reg(CSR_SPARE_LOW, 16'h1234);
      write_reg(CSR_SPARE_LOW + 3'd1, 16'hFFFF);
      write_reg(CSR_SPARE_HIGH, 16'h0001);
      settings_used++;
      @(posedge clock);
      queue_move(65535, 16384, -16384);
      queue_move(0, 0, 0);
      queue_move(40000, -32768, 32767);
      wait_idle();

      // limits at the 14 bit extremes, pitch past a quarter turn
      write_reg(CSR_PITCH_FLOOR, 16'hE000);
      write_reg(CSR_PITCH_CEILING, 16'h1FFF);
      write_reg(CSR_PITCH_RATE, 16'h7FFF);
      write_reg(CSR_YAW_RATE, 16'h0000);
      settings_used++;
      @(posedge clock);
      queue_move(65535, 16384, -32768);
      queue_move(65535, 16384, 32767);
      queue_move(0, 0, 0);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_settings();
         @(posedge clock);
         steady = (phase == STEADY_PHASE);
         for (k = 0; k < MOVES_PER_PHASE; k++) begin
            case ($urandom_range(0, 9))
               0: dt = '0;
               1: dt = '1;
               2, 3, 4: dt = DT_W'($urandom_range(1, 2048));
               default: dt = DT_W'($urandom);
            endcase
            queue_move(dt, random_axis(), random_axis());
         end
         wait_idle();
         steady = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (views_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", views_due.size()));
      end
      $display("covered %0d camera steps and %0d checked results over %0d register settings",
               req_accepted, results_seen, settings_used);
      $display("including zero time steps, crossed and out-of-range pitch limits, yaw wrap");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
